// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the evidence counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define RMEC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RMEC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rmec_pkg.sv =====
// ----------------------------------------------------------------------------
// rmec_pkg
// Types, constants and codes shared by the read mismatch evidence counter.
// ----------------------------------------------------------------------------
package rmec_pkg;

  localparam int WINDOW_SIZE     = 4096;
  localparam int WIN_AW          = $clog2(WINDOW_SIZE);
  localparam int MAX_READ_LENGTH = 512;
  localparam int QAW             = $clog2(MAX_READ_LENGTH);
  localparam int QCW             = QAW + 1;
  localparam int CNT_W           = 4;
  localparam int ROW_W           = 3 * CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX      = 4'd15;
  localparam logic [11:0]      SKIP_FLAG_MASK = 12'h604;

  localparam logic [31:0] REGION_START_RST = 32'd0;
  localparam logic [6:0]  MIN_BQ_RST       = 7'd20;
  localparam logic [3:0]  HIT_THR_RST      = 4'd2;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'd32;

  typedef enum logic [2:0] {
    OP_READ_START = 3'd0,
    OP_QUALITY    = 3'd1,
    OP_MD_CHAR    = 3'd2,
    OP_CIGAR      = 3'd3,
    OP_CLEAR      = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    CG_M = 4'd0, CG_I = 4'd1, CG_D = 4'd2, CG_N = 4'd3, CG_S = 4'd4,
    CG_H = 4'd5, CG_P = 4'd6, CG_EQ = 4'd7, CG_X = 4'd8
  } cigar_e;

  typedef enum logic [1:0] {
    REG_REGION_START = 2'd0,
    REG_MIN_BQ       = 2'd1,
    REG_HIT_THR      = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SKIP   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_NOQUAL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TBL_MM  = 2'd0,
    TBL_INS = 2'd1,
    TBL_DEL = 2'd2
  } tbl_e;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_CHECK, S_BUMP, S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic check;
    logic bump;
    logic clear;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic exec_check;
    logic exec_clear;
    logic check_bump;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/read_mismatch_evidence_counter.sv =====
// Read mismatch evidence counter: accepts one item on the input channel
// (in_valid_i / in_stall_o) and returns one result (active flag and status)
// on the output channel (out_valid_o / out_stall_i). The user must write the
// configuration registers through cfg_we_i, cfg_idx_i and cfg_wdata_i only
// while the block is idle; the block has no check of its own for this.
// Items are worked one at a time, and in_stall_o is high while one is in
// flight. A read start, quality byte or plain MD character runs through the
// execute and done states; a count position adds a check state and, if it is
// in the window and passes the quality check, a bump state in which the count
// table row read in the check state is bumped and written back. A clear-tables
// item sweeps all 4096 rows, one row a cycle, then answers. After reset the
// same clearing pass runs before the first item is accepted. A finished result
// waits in the output register while the receiver stalls; the next item is
// then accepted and run, and only its hand-off waits.
// ----------------------------------------------------------------------------
// read_mismatch_evidence_counter
// Top level: sequencer and datapath of the per-position evidence counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module read_mismatch_evidence_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] read_start_i,
  input  logic [11:0] sam_flags_i,
  input  logic [7:0]  mapping_quality_i,
  input  logic [6:0]  base_quality_i,
  input  logic [7:0]  md_char_i,
  input  logic [3:0]  cigar_op_i,
  input  logic [27:0] cigar_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        active_o,
  output logic [1:0]  status_o
);
  import rmec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the handshake toward the sender.
  rmec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath holds the tables, the read state and the result register.
  rmec_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .read_start_i      (read_start_i),
    .sam_flags_i       (sam_flags_i),
    .mapping_quality_i (mapping_quality_i),
    .base_quality_i    (base_quality_i),
    .md_char_i         (md_char_i),
    .cigar_op_i        (cigar_op_i),
    .cigar_length_i    (cigar_length_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .active_o          (active_o),
    .status_o          (status_o)
  );

  // No item is taken during a clearing sweep.
  `RMEC_ASSERT(a_clear_blocks_input, clk_i, rst_ni, cmd.clear |-> in_stall_o, "item during clear")
  // An accepted item closes the input until its result is handed off.
  `RMEC_ASSERT(a_accept_closes, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "input open after accept")
  // A result is loaded only while the input is closed.
  `RMEC_ASSERT(a_emit_when_busy, clk_i, rst_ni, cmd.emit |-> in_stall_o, "result with open input")

endmodule

// ===== sv/rmec_ram.sv =====
// ----------------------------------------------------------------------------
// rmec_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/rmec_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmec_ctrl
// Sequencer: clearing sweep, item execution, count update and result hand-off.
// ----------------------------------------------------------------------------
module rmec_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  rmec_pkg::sts_t sts_i,
  output rmec_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import rmec_pkg::*;

  state_e state_q, state_d;
  logic   clr_reply_q, clr_reply_d;

  always_comb begin
    state_d     = state_q;
    clr_reply_d = clr_reply_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d     = clr_reply_q ? S_DONE : S_IDLE;
          clr_reply_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (sts_i.exec_clear) begin
          state_d     = S_CLEAR;
          clr_reply_d = 1'b1;
        end else if (sts_i.exec_check) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        state_d = sts_i.check_bump ? S_BUMP : S_DONE;
      end
      S_BUMP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE:  cmd_o.load  = in_valid_i;
      S_EXEC:  cmd_o.exec  = 1'b1;
      S_CHECK: cmd_o.check = 1'b1;
      S_BUMP:  cmd_o.bump  = 1'b1;
      S_DONE:  cmd_o.emit  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_reply_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_reply_q <= clr_reply_d;
    end
  end

endmodule

// ===== sv/rmec_dp.sv =====
// ----------------------------------------------------------------------------
// rmec_dp
// Datapath: read state, MD and CIGAR decoding, count tables, result register.
// ----------------------------------------------------------------------------
module rmec_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmec_pkg::cmd_t cmd_i,
  output rmec_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i,
  input  logic [2:0]     opcode_i,
  input  logic [31:0]    read_start_i,
  input  logic [11:0]    sam_flags_i,
  input  logic [7:0]     mapping_quality_i,
  input  logic [6:0]     base_quality_i,
  input  logic [7:0]     md_char_i,
  input  logic [3:0]     cigar_op_i,
  input  logic [27:0]    cigar_length_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           active_o,
  output logic [1:0]     status_o
);
  import rmec_pkg::*;

  // Latched item.
  logic [2:0]  op_q;
  logic [31:0] start_q;
  logic [11:0] flags_q;
  logic [7:0]  mapq_q, mdc_q;
  logic [6:0]  bq_q;
  logic [3:0]  cop_q;
  logic [27:0] clen_q;

  // Configuration.
  logic [31:0] region_q;
  logic [6:0]  minq_q;
  logic [3:0]  thr_q;

  // Read state.
  logic [QCW-1:0] qcnt_q, qcnt_d;
  logic [31:0] md_pos_q, md_pos_d, rd_off_q, rd_off_d, run_q, run_d, cig_q, cig_d;
  logic in_del_q, in_del_d, rd_en_q, rd_en_d, md_en_q, md_en_d, active_q, active_d;

  // Count update context.
  logic [31:0]       bump_pos_q, bump_pos_d;
  logic              bump_md_q, bump_md_d, acgt_q, acgt_d;
  tbl_e              sel_q, sel_d;
  logic [WIN_AW-1:0] idx_q, idx_d, clr_cnt_q;
  status_e           st_q, st_d;

  logic       out_valid_q;
  logic       out_active_q;
  status_e    out_status_q;

  // RAM ports.
  logic             q_we;
  logic [QAW-1:0]   q_raddr;
  logic [6:0]       q_rdata;
  logic             c_we;
  logic [WIN_AW-1:0] c_waddr, c_raddr;
  logic [ROW_W-1:0] c_wdata, c_rdata;

  // Decode helpers.
  logic [7:0]  up;
  logic        is_digit, is_letter, is_acgt;
  logic [3:0]  digit;
  logic [35:0] run_prod;
  logic [31:0] pos_fl, off_fl, cig_new, idx_full;
  logic        go;
  logic [CNT_W-1:0] old_cnt, new_cnt;
  logic        exec_check, exec_clear;

  assign is_digit = (mdc_q >= CH_0) && (mdc_q <= CH_9);
  assign digit    = 4'(mdc_q - CH_0);
  assign run_prod = {1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0} + {32'd0, digit};
  assign up       = ((mdc_q >= CH_LA) && (mdc_q <= CH_LZ)) ? (mdc_q - CASE_GAP) : mdc_q;
  assign is_letter = (up >= CH_A) && (up <= CH_Z);
  assign is_acgt  = (up == CH_A) || (up == CH_C) || (up == CH_G) || (up == CH_T);
  assign pos_fl   = md_pos_q + run_q;
  assign off_fl   = rd_off_q + run_q;
  assign q_raddr  = off_fl[QAW-1:0];
  assign cig_new  = cig_q + {4'd0, clen_q};
  assign idx_full = bump_pos_q - region_q;
  assign go       = bump_md_q ? ((q_rdata >= minq_q) && acgt_q) : 1'b1;
  assign c_raddr  = idx_full[WIN_AW-1:0];

  always_comb begin
    case (sel_q)
      TBL_INS: old_cnt = c_rdata[2*CNT_W-1:CNT_W];
      TBL_DEL: old_cnt = c_rdata[3*CNT_W-1:2*CNT_W];
      default: old_cnt = c_rdata[CNT_W-1:0];
    endcase
    new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 4'd1;
    c_wdata = c_rdata;
    case (sel_q)
      TBL_INS: c_wdata[2*CNT_W-1:CNT_W]   = new_cnt;
      TBL_DEL: c_wdata[3*CNT_W-1:2*CNT_W] = new_cnt;
      default: c_wdata[CNT_W-1:0]         = new_cnt;
    endcase
    if (cmd_i.clear) c_wdata = '0;
  end

  assign c_we    = cmd_i.clear || cmd_i.bump;
  assign c_waddr = cmd_i.clear ? clr_cnt_q : idx_q;
  assign q_we    = cmd_i.exec && (op_q == OP_QUALITY) && rd_en_q &&
                   (qcnt_q < QCW'(MAX_READ_LENGTH));

  always_comb begin
    qcnt_d = qcnt_q;  md_pos_d = md_pos_q;  rd_off_d = rd_off_q;
    run_d = run_q;    cig_d = cig_q;        in_del_d = in_del_q;
    rd_en_d = rd_en_q; md_en_d = md_en_q;   active_d = active_q;
    bump_pos_d = bump_pos_q; bump_md_d = bump_md_q; acgt_d = acgt_q;
    sel_d = sel_q; idx_d = idx_q; st_d = st_q;
    exec_check = 1'b0;
    exec_clear = 1'b0;

    if (cmd_i.exec) begin
      st_d = ST_OK;
      if ((op_q == OP_QUALITY || op_q == OP_MD_CHAR || op_q == OP_CIGAR) && !rd_en_q) begin
        st_d = ST_SKIP;
      end else begin
        unique case (op_q)
          OP_READ_START: begin
            rd_en_d  = !(((flags_q & SKIP_FLAG_MASK) != 12'd0) || (mapq_q == 8'd0));
            md_en_d  = !start_q[31];
            md_pos_d = start_q;
            cig_d    = start_q;
            rd_off_d = '0;
            run_d    = '0;
            qcnt_d   = '0;
            in_del_d = 1'b0;
            st_d     = rd_en_d ? ST_OK : ST_SKIP;
          end
          OP_QUALITY: begin
            if (q_we) qcnt_d = qcnt_q + QCW'(1);
          end
          OP_MD_CHAR: begin
            if (md_en_q) begin
              if (is_digit) begin
                run_d    = (run_prod[35:32] != 4'd0) ? '1 : run_prod[31:0];
                in_del_d = 1'b0;
              end else begin
                run_d    = '0;
                md_pos_d = pos_fl;
                rd_off_d = off_fl;
                if (mdc_q == CH_CARET) begin
                  in_del_d = 1'b1;
                end else if (is_letter) begin
                  md_pos_d = md_pos_q + run_q + 32'd1;
                  if (!in_del_q) begin
                    rd_off_d = rd_off_q + run_q + 32'd1;
                    if (off_fl >= {{(32-QCW){1'b0}}, qcnt_q}) begin
                      st_d = ST_NOQUAL;
                    end else begin
                      bump_pos_d = pos_fl;
                      bump_md_d  = 1'b1;
                      acgt_d     = is_acgt;
                      sel_d      = TBL_MM;
                      exec_check = 1'b1;
                    end
                  end
                end
              end
            end
          end
          OP_CIGAR: begin
            case (cop_q)
              CG_M, CG_N, CG_EQ: cig_d = cig_new;
              CG_D: begin
                cig_d = cig_new; bump_pos_d = cig_new; sel_d = TBL_DEL;
                bump_md_d = 1'b0; exec_check = 1'b1;
              end
              CG_X: begin
                cig_d = cig_new; bump_pos_d = cig_new; sel_d = TBL_MM;
                bump_md_d = 1'b0; exec_check = 1'b1;
              end
              CG_I: begin
                bump_pos_d = cig_q; sel_d = TBL_INS;
                bump_md_d = 1'b0; exec_check = 1'b1;
              end
              default: ;
            endcase
          end
          OP_CLEAR: exec_clear = 1'b1;
          default: ;
        endcase
      end
    end

    if (cmd_i.check) begin
      idx_d = idx_full[WIN_AW-1:0];
      if (go && (idx_full[31:WIN_AW] != '0)) st_d = ST_RANGE;
    end

    if (cmd_i.bump && (new_cnt >= thr_q)) active_d = 1'b1;
  end

  assign sts_o.exec_check = exec_check;
  assign sts_o.exec_clear = exec_clear;
  assign sts_o.check_bump = go && (idx_full[31:WIN_AW] == '0);
  assign sts_o.clr_last   = (clr_cnt_q == '1);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  rmec_ram #(.WIDTH(7), .DEPTH(MAX_READ_LENGTH)) u_qual_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (qcnt_q[QAW-1:0]),
    .wdata_i (bq_q),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  rmec_ram #(.WIDTH(ROW_W), .DEPTH(WINDOW_SIZE)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;  start_q <= read_start_i;  flags_q <= sam_flags_i;
      mapq_q <= mapping_quality_i;  bq_q <= base_quality_i;  mdc_q <= md_char_i;
      cop_q <= cigar_op_i;  clen_q <= cigar_length_i;
    end
    if (cmd_i.emit) begin
      out_active_q <= active_q;
      out_status_q <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= REGION_START_RST;  minq_q <= MIN_BQ_RST;  thr_q <= HIT_THR_RST;
      qcnt_q <= '0;  md_pos_q <= '0;  rd_off_q <= '0;  run_q <= '0;  cig_q <= '0;
      in_del_q <= 1'b0;  rd_en_q <= 1'b0;  md_en_q <= 1'b0;  active_q <= 1'b0;
      bump_pos_q <= '0;  bump_md_q <= 1'b0;  acgt_q <= 1'b0;  sel_q <= TBL_MM;
      idx_q <= '0;  st_q <= ST_OK;  clr_cnt_q <= '0;  out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_REGION_START: region_q <= cfg_wdata_i;
          REG_MIN_BQ:       minq_q   <= cfg_wdata_i[6:0];
          REG_HIT_THR:      thr_q    <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      qcnt_q <= qcnt_d;  md_pos_q <= md_pos_d;  rd_off_q <= rd_off_d;  run_q <= run_d;
      cig_q <= cig_d;  in_del_q <= in_del_d;  rd_en_q <= rd_en_d;  md_en_q <= md_en_d;
      active_q <= active_d;  bump_pos_q <= bump_pos_d;  bump_md_q <= bump_md_d;
      acgt_q <= acgt_d;  sel_q <= sel_d;  idx_q <= idx_d;  st_q <= st_d;
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + WIN_AW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign active_o    = out_active_q;
  assign status_o    = out_status_q;

endmodule

// ===== sim/read_mismatch_evidence_counter_tb.sv =====
// ----------------------------------------------------------------------------
// read_mismatch_evidence_counter_tb
// Self-checking bench: feeds read starts, qualities, MD characters, CIGAR
// units and table clears, predicts active/status, compares every result.
// ----------------------------------------------------------------------------
module read_mismatch_evidence_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmec_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [2:0]  opc;
    logic [31:0] start;
    logic [11:0] flags;
    logic [7:0]  mapq;
    logic [6:0]  bq;
    logic [7:0]  mdc;
    logic [3:0]  cop;
    logic [27:0] clen;
  } item_t;

  typedef struct {
    logic    active;
    status_e status;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [31:0] read_start_i = '0;
  logic [11:0] sam_flags_i = '0;
  logic [7:0]  mapping_quality_i = '0;
  logic [6:0]  base_quality_i = '0;
  logic [7:0]  md_char_i = '0;
  logic [3:0]  cigar_op_i = '0;
  logic [27:0] cigar_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        active_o;
  logic [1:0]  status_o;

  read_mismatch_evidence_counter DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending stimulus and the verdicts the predictor expects, oldest first.
  item_t    stim_q[$];
  verdict_t verdict_q[$];
  int       errors = 0;
  bit       no_gaps = 1'b0;

  // Predictor copy of the configuration and the block state.
  logic [31:0] p_region = REGION_START_RST;
  logic [6:0]  p_minbq  = MIN_BQ_RST;
  logic [3:0]  p_thr    = HIT_THR_RST;
  logic [3:0]  mm_tbl[WINDOW_SIZE];
  logic [3:0]  ins_tbl[WINDOW_SIZE];
  logic [3:0]  del_tbl[WINDOW_SIZE];
  logic [6:0]  qual_mem[MAX_READ_LENGTH];
  logic [31:0] qual_cnt, md_pos, rd_off, run_len, cg_pos;
  logic        in_del, rd_en, act, md_en;

  initial begin
    foreach (mm_tbl[i]) begin
      mm_tbl[i] = '0; ins_tbl[i] = '0; del_tbl[i] = '0;
    end
    qual_cnt = '0; md_pos = '0; rd_off = '0; run_len = '0; cg_pos = '0;
    in_del = 1'b0; rd_en = 1'b0; act = 1'b0; md_en = 1'b0;
  end

  // Saturating count at one genome position; out-of-window gives a range status.
  function automatic status_e count_hit(ref logic [3:0] tbl[WINDOW_SIZE],
                                        input logic [31:0] pos);
    logic [31:0] idx;
    idx = pos - p_region;
    if (idx >= WINDOW_SIZE) return ST_RANGE;
    if (tbl[idx] < COUNT_MAX) tbl[idx] = tbl[idx] + 4'd1;
    if (tbl[idx] >= p_thr) act = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_e md_char_effect(logic [7:0] c);
    logic [31:0] d;
    logic [7:0]  up;
    status_e     st;
    st = ST_OK;
    if (c >= CH_0 && c <= CH_9) begin
      d = 32'(c - CH_0);
      if (run_len > (32'hFFFF_FFFF - d) / 10) run_len = 32'hFFFF_FFFF;
      else run_len = run_len * 10 + d;
      in_del = 1'b0;
      return ST_OK;
    end
    md_pos = md_pos + run_len;
    rd_off = rd_off + run_len;
    run_len = '0;
    if (c == CH_CARET) begin
      in_del = 1'b1;
      return ST_OK;
    end
    up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_GAP : c;
    if (up < CH_A || up > CH_Z) return ST_OK;
    if (in_del) begin
      md_pos = md_pos + 1;
      return ST_OK;
    end
    if (rd_off >= qual_cnt || rd_off >= MAX_READ_LENGTH) st = ST_NOQUAL;
    else if (qual_mem[rd_off] >= p_minbq &&
             (up == CH_A || up == CH_C || up == CH_G || up == CH_T))
      st = count_hit(mm_tbl, md_pos);
    md_pos = md_pos + 1;
    rd_off = rd_off + 1;
    return st;
  endfunction

  function automatic status_e cigar_effect(logic [3:0] op, logic [27:0] len);
    if (op > CG_X) return ST_OK;
    if (op == CG_M || op == CG_D || op == CG_N || op == CG_EQ || op == CG_X)
      cg_pos = cg_pos + 32'(len);
    if (op == CG_I) return count_hit(ins_tbl, cg_pos);
    if (op == CG_D) return count_hit(del_tbl, cg_pos);
    if (op == CG_X) return count_hit(mm_tbl, cg_pos);
    return ST_OK;
  endfunction

  function automatic void predict_verdict(item_t it);
    verdict_t v;
    status_e  st;
    st = ST_OK;
    if (it.opc == OP_READ_START) begin
      rd_en = !((it.flags & SKIP_FLAG_MASK) != 0 || it.mapq == 0);
      md_en = !it.start[31];
      md_pos = it.start; cg_pos = it.start;
      rd_off = '0; run_len = '0; qual_cnt = '0; in_del = 1'b0;
      st = rd_en ? ST_OK : ST_SKIP;
    end else if (it.opc >= OP_QUALITY && it.opc <= OP_CIGAR && !rd_en) begin
      st = ST_SKIP;
    end else if (it.opc == OP_QUALITY) begin
      if (qual_cnt < MAX_READ_LENGTH) begin
        qual_mem[qual_cnt] = it.bq;
        qual_cnt = qual_cnt + 1;
      end
    end else if (it.opc == OP_MD_CHAR) begin
      if (md_en) st = md_char_effect(it.mdc);
    end else if (it.opc == OP_CIGAR) begin
      st = cigar_effect(it.cop, it.clen);
    end else if (it.opc == OP_CLEAR) begin
      foreach (mm_tbl[i]) begin
        mm_tbl[i] = '0; ins_tbl[i] = '0; del_tbl[i] = '0;
      end
    end
    v.active = act;
    v.status = st;
    verdict_q.push_back(v);
  endfunction

  // Gaps: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: holds a stalled item, otherwise pops the next one after its gap.
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_verdict('{opcode_i, read_start_i, sam_flags_i, mapping_quality_i,
                          base_quality_i, md_char_i, cigar_op_i, cigar_length_i});
        gap_left = pick_gap();
      end
      if (in_valid_i && in_stall_o) begin
        // The stalled item stays on the wires.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (stim_q.size() > 0) begin
        it = stim_q.pop_front();
        opcode_i          <= it.opc;
        read_start_i      <= it.start;
        sam_flags_i       <= it.flags;
        mapping_quality_i <= it.mapq;
        base_quality_i    <= it.bq;
        md_char_i         <= it.mdc;
        cigar_op_i        <= it.cop;
        cigar_length_i    <= it.clen;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest verdict and stalls at random.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result active %0d status %0d", $realtime,
                   active_o, status_o);
          errors++;
        end else begin
          v = verdict_q.pop_front();
          if (active_o !== v.active) begin
            $display("%0t: active expected %0d actual %0d", $realtime, v.active,
                     active_o);
            errors++;
          end
          if (status_o !== v.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, v.status,
                     status_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_left = pick_gap();
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // Watchdog on cycles with no traffic on either channel.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("read_mismatch_evidence_counter_tb: done, errors");
      $finish;
    end
  end

  // Item builders. Fields the opcode ignores carry random noise.
  function automatic item_t noise_item(logic [2:0] opc);
    item_t it;
    it.opc = opc; it.start = $urandom; it.flags = 12'($urandom);
    it.mapq = 8'($urandom); it.bq = 7'($urandom_range(0, 93));
    it.mdc = 8'($urandom); it.cop = 4'($urandom); it.clen = 28'($urandom);
    return it;
  endfunction

  task automatic add_start(logic [31:0] s, logic [11:0] f, logic [7:0] q);
    item_t it;
    it = noise_item(OP_READ_START);
    it.start = s; it.flags = f; it.mapq = q;
    stim_q.push_back(it);
  endtask

  task automatic add_qual(logic [6:0] q);
    item_t it;
    it = noise_item(OP_QUALITY);
    it.bq = q;
    stim_q.push_back(it);
  endtask

  task automatic add_md(logic [7:0] c);
    item_t it;
    it = noise_item(OP_MD_CHAR);
    it.mdc = c;
    stim_q.push_back(it);
  endtask

  task automatic add_cigar(logic [3:0] op, logic [27:0] len);
    item_t it;
    it = noise_item(OP_CIGAR);
    it.cop = op; it.clen = len;
    stim_q.push_back(it);
  endtask

  // One random read: mostly well formed, landing near the window so counts build up.
  task automatic add_read(int nq_max);
    int r, n;
    logic [31:0] s;
    logic [11:0] f;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 70) s = p_region + $urandom_range(0, 80);
    else if (r < 85) s = p_region + $urandom_range(0, 4200);
    else if (r < 92) s = 32'hFFFF_FFFF;
    else s = $urandom;
    f = 12'($urandom);
    if ($urandom_range(0, 99) < 85) f = f & ~SKIP_FLAG_MASK;
    add_start(s, f, ($urandom_range(0, 99) < 7) ? 8'd0 : 8'($urandom_range(1, 255)));
    n = $urandom_range(0, nq_max);
    repeat (n) add_qual(7'($urandom_range(0, 93)));
    n = $urandom_range(0, 16);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) c = CH_0 + 8'($urandom_range(0, 9));
      else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: c = CH_A;
          1: c = CH_C;
          2: c = CH_G;
          default: c = CH_T;
        endcase
        if ($urandom_range(0, 3) == 0) c = c + CASE_GAP;
      end else if (r < 78) c = CH_CARET;
      else if (r < 85) c = CH_A + 8'($urandom_range(0, 25));
      else c = 8'($urandom);
      add_md(c);
    end
    n = $urandom_range(0, 5);
    repeat (n) begin
      r = $urandom_range(0, 99);
      add_cigar((r < 90) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15)),
                (r % 20 < 16) ? 28'($urandom_range(0, 20)) :
                (r % 20 < 19) ? 28'($urandom_range(0, 5000)) : 28'($urandom));
    end
    if ($urandom_range(0, 99) < 5) begin
      stim_q.push_back(noise_item(3'($urandom_range(5, 7))));
      stim_q.push_back(noise_item(3'($urandom_range(1, 3))));
    end
  endtask

  // Sampled at the falling edge, when the driver's updates have settled.
  task automatic wait_idle();
    while (stim_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    case (idx)
      REG_REGION_START: p_region = val;
      REG_MIN_BQ:       p_minbq  = val[6:0];
      default:          p_thr    = val[3:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] reg0, logic [6:0] mbq, logic [3:0] thr,
                           int items, bit gapless);
    wait_idle();
    write_reg(REG_REGION_START, reg0);
    write_reg(REG_MIN_BQ, 32'(mbq));
    write_reg(REG_HIT_THR, 32'(thr));
    no_gaps = gapless;
    while (stim_q.size() < items) add_read(24);
    if ($urandom_range(0, 1)) stim_q.push_back(noise_item(OP_CLEAR));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset configuration.
    add_qual(7'd5);                       // no read yet: skipped
    add_start(32'd10, 12'h004, 8'd60);    // unmapped read
    add_md(CH_A);
    add_start(32'd10, 12'h400, 8'd60);    // duplicate
    add_start(32'd10, 12'h001, 8'd0);     // mapping quality zero
    add_start(32'd10, 12'h9FB, 8'd255);   // kept read
    add_qual(7'd93); add_qual(7'd0); add_qual(7'd30);
    add_md(CH_A);                         // counted at 10
    add_md(CH_G + CASE_GAP);              // low quality
    add_md(CH_C + CASE_GAP);              // counted at 12
    add_md(CH_CARET); add_md(CH_G); add_md(CH_T);  // deletion bases
    add_md(CH_0 + 8'd1);
    add_md(CH_T);                         // past the loaded qualities
    add_md(8'h4E); add_md(8'h23); add_md(8'hFF);
    add_cigar(CG_M, 28'd2); add_cigar(CG_I, 28'd0); add_cigar(CG_D, 28'd1);
    add_cigar(CG_X, 28'd0); add_cigar(CG_X, 28'hFFF_FFFF); add_cigar(4'd15, 28'd1);
    stim_q.push_back(noise_item(3'd7));
    stim_q.push_back(noise_item(OP_CLEAR));
    add_start(32'hFFFF_FFFF, 12'h000, 8'd1);  // negative start: MD ignored
    add_md(CH_A); add_cigar(CG_I, 28'd0);

    // A read carrying more qualities than the store holds.
    wait_idle();
    add_read(0);
    repeat (MAX_READ_LENGTH + 3) add_qual(7'($urandom_range(0, 93)));
    add_md(CH_9); add_md(CH_9); add_md(CH_A);

    // Sender holds off until everything has come back, then the phases run.
    run_phase(32'd0, 7'd0, 4'd1, 240, 1'b0);
    run_phase(32'hFFFF_FFFF, 7'd93, 4'd15, 200, 1'b1);
    run_phase(32'h7FFF_FFC0, 7'd20, 4'd2, 240, 1'b0);
    run_phase(32'hFFFF_F800, 7'($urandom_range(0, 93)), 4'($urandom_range(1, 15)),
              240, 1'b0);
    run_phase($urandom, 7'($urandom_range(0, 93)), 4'($urandom_range(1, 15)),
              240, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("read_mismatch_evidence_counter_tb: done, clean");
    end else begin
      $display("read_mismatch_evidence_counter_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rmec_pkg.sv
sv/rmec_ram.sv
sv/rmec_ctrl.sv
sv/rmec_dp.sv
sv/read_mismatch_evidence_counter.sv
sim/read_mismatch_evidence_counter_tb.sv
